FILE: src/wprm_pkg.sv
`timescale 1ns / 1ps

package wprm_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 1'b1;

  // Register widths and reset values
  localparam int CC_W          = 4;
  localparam int WIN_W         = 24;
  localparam int CFG_DATA_W    = 24;
  localparam int CC_RESET      = 2;
  localparam int WIN_RESET     = 1024;

  // Scaling constants
  localparam int LEVEL_SCALE   = 1000;
  localparam int RMS_SCALE     = 1000000;

  // Result field widths
  localparam int PEAK_W        = 11;
  localparam int RMS_W         = 10;
  localparam int OUT_DATA_W    = 32;
  localparam int OUT_USER_W    = 3;

  // Datapath widths: square sum, long division and the shared subtractor
  localparam int SQ_W          = 64;
  localparam int MUL_W         = 33;
  localparam int DIV_W         = 84;
  localparam int REM_W         = 24;
  localparam int SUB_W         = 65;
  localparam int CNT_W         = 7;
  localparam int SQRT_STEPS    = 32;
  localparam logic [SQ_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  // Sequencer states
  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0_0000_0000_0001,
    ST_SQR   = 13'b0_0000_0000_0010,
    ST_ACC   = 13'b0_0000_0000_0100,
    ST_DIVCH = 13'b0_0000_0000_1000,
    ST_DFIX  = 13'b0_0000_0001_0000,
    ST_MLO   = 13'b0_0000_0010_0000,
    ST_MHI   = 13'b0_0000_0100_0000,
    ST_MADD  = 13'b0_0000_1000_0000,
    ST_DIV   = 13'b0_0001_0000_0000,
    ST_SQSET = 13'b0_0010_0000_0000,
    ST_SQRT  = 13'b0_0100_0000_0000,
    ST_FMT   = 13'b0_1000_0000_0000,
    ST_OUT   = 13'b1_0000_0000_0000
  } state_t;

endpackage

FILE: src/windowed_peak_rms_meter.sv
// Per sample: after a transaction the block squares and accumulates before it is ready again.
// Window close: a 24-step channel-count divide, then per channel 84 divide steps and 32 root
// steps on the shared subtractor, then the first result is shown; each further channel starts
// its multiply, divide and root steps once the previous result is taken.
// Synchronous active-low reset: idle, registers to their defaults, accumulators cleared.
`timescale 1ns / 1ps

module windowed_peak_rms_meter #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic [wprm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wprm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // Sample stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // in_tdata: sample (SAMPLE_BITS, signed), upper bits padding
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  // Level results
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_tdata: peak_high [10:0], peak_low [21:11], rms_level [31:22]
  output logic [wprm_pkg::OUT_DATA_W-1:0]        out_tdata,
  // out_tuser: channel [2:0]
  output logic [wprm_pkg::OUT_USER_W-1:0]        out_tuser,
  output logic                                   out_tlast
);

  import wprm_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int MM_W  = SB + 1;
  localparam int PK_W  = MM_W + 11;
  localparam int SH    = 2 * (SB - 1);
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EFF_W = $clog2(MAX_CHANNELS + 1);

  localparam logic [4:0]              MAX5     = 5'(MAX_CHANNELS);
  localparam logic signed [MM_W-1:0]  MM_POS   = {2'b01, {(SB-1){1'b0}}};
  localparam logic signed [MM_W-1:0]  MM_NEG   = {2'b11, {(SB-1){1'b0}}};
  localparam logic signed [PK_W-1:0]  PK_SCALE = PK_W'(LEVEL_SCALE);
  localparam logic signed [PK_W-1:0]  PK_ROUND = PK_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [DIV_W-1:0]        SAT_LIM  = DIV_W'(RMS_SCALE) << (SH + 1);

  // Control state
  state_t                    state_r, state_nxt;
  logic [CC_W-1:0]           chan_cnt_r, chan_cnt_nxt;
  logic [WIN_W-1:0]          win_samp_r, win_samp_nxt;
  logic [WIN_W-1:0]          win_cnt_r, win_cnt_nxt;
  logic [CH_W-1:0]           pos_r, pos_nxt;
  logic signed [MM_W-1:0]    max_r [MAX_CHANNELS];
  logic signed [MM_W-1:0]    max_nxt [MAX_CHANNELS];
  logic signed [MM_W-1:0]    min_r [MAX_CHANNELS];
  logic signed [MM_W-1:0]    min_nxt [MAX_CHANNELS];
  logic [SQ_W-1:0]           sum_r [MAX_CHANNELS];
  logic [SQ_W-1:0]           sum_nxt [MAX_CHANNELS];
  logic                      out_valid_r, out_valid_nxt;

  // Datapath registers
  logic signed [SB-1:0]      s_r, s_nxt;
  logic [CH_W-1:0]           idx_r, idx_nxt;
  logic [SQ_W-1:0]           prod_r, prod_nxt;
  logic [DIV_W-1:0]          dq_r, dq_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [REM_W-1:0]          den_r, den_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [SQ_W-1:0]           x_r, x_nxt;
  logic [SQ_W-1:0]           root_r, root_nxt;
  logic [SQ_W-1:0]           bit_r, bit_nxt;
  logic                      sat_r, sat_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]     out_user_r, out_user_nxt;
  logic                      out_last_r, out_last_nxt;

  // Combinational helpers
  logic [4:0]                eff5;
  logic [EFF_W-1:0]          eff;
  logic [CH_W-1:0]           ch_sel;
  logic [EFF_W-1:0]          ch_inc;
  logic [CH_W-1:0]           pos_next_val;
  logic [WIN_W-1:0]          win_inc;
  logic signed [MM_W-1:0]    s_ext;
  logic signed [MM_W-1:0]    max_rd, min_rd;
  logic [SQ_W-1:0]           sum_rd;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [SUB_W-1:0]          sub_a, sub_b, sub_d;
  logic                      borrow;
  logic signed [PK_W-1:0]    hi_mul, lo_mul, hi_adj, lo_adj, hi_q, lo_q;
  logic [RMS_W-1:0]          rms_val;

  // Effective channel count: zero counts as one, large values clamp
  always_comb begin
    if (chan_cnt_r == '0) begin
      eff5 = 5'd1;
    end else if ({1'b0, chan_cnt_r} > MAX5) begin
      eff5 = MAX5;
    end else begin
      eff5 = {1'b0, chan_cnt_r};
    end
  end
  assign eff = EFF_W'(eff5);

  // Round-robin channel selection for the incoming sample
  assign ch_sel       = (EFF_W'(pos_r) >= eff) ? '0 : pos_r;
  assign ch_inc       = EFF_W'(ch_sel) + EFF_W'(1);
  assign pos_next_val = (ch_inc >= eff) ? '0 : CH_W'(ch_inc);
  assign win_inc      = win_cnt_r + WIN_W'(1);

  // Accumulator read port, addressed by the working channel only
  assign s_ext  = MM_W'(s_r);
  assign max_rd = max_r[idx_r];
  assign min_rd = min_r[idx_r];
  assign sum_rd = sum_r[idx_r];

  // Shared multiplier: sample square, or a half of the square sum times one million
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQR) begin
      mul_a = MUL_W'(s_r);
      mul_b = MUL_W'(s_r);
    end else if (state_r == ST_MLO) begin
      mul_a = $signed({1'b0, sum_rd[31:0]});
      mul_b = MUL_W'(RMS_SCALE);
    end else if (state_r == ST_MHI) begin
      mul_a = $signed({1'b0, sum_rd[63:32]});
      mul_b = MUL_W'(RMS_SCALE);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Shared subtractor: restoring division step, or square root step
  always_comb begin
    if (state_r == ST_SQRT) begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, root_r | bit_r};
    end else begin
      sub_a = SUB_W'({rem_r, dq_r[DIV_W-1]});
      sub_b = SUB_W'(den_r);
    end
  end
  assign sub_d  = sub_a - sub_b;
  assign borrow = sub_d[SUB_W-1];

  // Peak scaling: times 1000, divided by full scale, truncated toward zero
  assign hi_mul  = PK_W'(max_rd) * PK_SCALE;
  assign lo_mul  = PK_W'(min_rd) * PK_SCALE;
  assign hi_adj  = hi_mul + (hi_mul[PK_W-1] ? PK_ROUND : '0);
  assign lo_adj  = lo_mul + (lo_mul[PK_W-1] ? PK_ROUND : '0);
  assign hi_q    = hi_adj >>> (SB - 1);
  assign lo_q    = lo_adj >>> (SB - 1);

  // Level saturates at full scale
  assign rms_val = (sat_r || (root_r > SQ_W'(LEVEL_SCALE))) ? RMS_W'(LEVEL_SCALE)
                                                            : root_r[RMS_W-1:0];

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    chan_cnt_nxt  = chan_cnt_r;
    win_samp_nxt  = win_samp_r;
    win_cnt_nxt   = win_cnt_r;
    pos_nxt       = pos_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    s_nxt         = s_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    sat_nxt       = sat_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    // Register writes are to arrive only while the block is idle; the block itself does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT:  chan_cnt_nxt = cfg_wdata[CC_W-1:0];
        CFG_WINDOW_SAMPLES: win_samp_nxt = cfg_wdata[WIN_W-1:0];
        default:            chan_cnt_nxt = chan_cnt_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          s_nxt     = in_tdata[SB-1:0];
          idx_nxt   = ch_sel;
          pos_nxt   = pos_next_val;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        prod_nxt = mul_p[SQ_W-1:0];
        if (s_ext < min_rd) begin
          min_nxt[idx_r] = s_ext;
        end
        if (s_ext > max_rd) begin
          max_nxt[idx_r] = s_ext;
        end
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        sum_nxt[idx_r] = sum_rd + prod_r;
        win_cnt_nxt    = win_inc;
        if (win_inc >= win_samp_r) begin
          // Per-channel sample count: window count over channel count
          dq_nxt    = {win_inc, {(DIV_W-WIN_W){1'b0}}};
          rem_nxt   = '0;
          den_nxt   = REM_W'(eff);
          cnt_nxt   = CNT_W'(WIN_W);
          state_nxt = ST_DIVCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVCH, ST_DIV: begin
        rem_nxt = borrow ? sub_a[REM_W-1:0] : sub_d[REM_W-1:0];
        dq_nxt  = {dq_r[DIV_W-2:0], ~borrow};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = (state_r == ST_DIVCH) ? ST_DFIX : ST_SQSET;
        end
      end
      ST_DFIX: begin
        // A zero divisor is raised to one
        den_nxt   = (dq_r[WIN_W-1:0] == '0) ? REM_W'(1) : dq_r[REM_W-1:0];
        idx_nxt   = '0;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        prod_nxt  = mul_p[SQ_W-1:0];
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        prod_nxt  = mul_p[SQ_W-1:0];
        dq_nxt    = DIV_W'(prod_r);
        state_nxt = ST_MADD;
      end
      ST_MADD: begin
        dq_nxt    = dq_r + (DIV_W'(prod_r) << 32);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DIV_W);
        state_nxt = ST_DIV;
      end
      ST_SQSET: begin
        sat_nxt   = (dq_r >= SAT_LIM);
        x_nxt     = dq_r[SQ_W-1:0] >> SH;
        root_nxt  = '0;
        bit_nxt   = SQRT_BIT0;
        cnt_nxt   = CNT_W'(SQRT_STEPS);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (!borrow) begin
          x_nxt    = sub_d[SQ_W-1:0];
          root_nxt = (root_r >> 1) | bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FMT;
        end
      end
      ST_FMT: begin
        out_data_nxt  = {rms_val, lo_q[PEAK_W-1:0], hi_q[PEAK_W-1:0]};
        out_user_nxt  = OUT_USER_W'(idx_r);
        out_last_nxt  = ((EFF_W'(idx_r) + EFF_W'(1)) == eff);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // Window finished: clear every accumulator and the sample count
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              max_nxt[i] = MM_NEG;
              min_nxt[i] = MM_POS;
              sum_nxt[i] = '0;
            end
            win_cnt_nxt = '0;
            state_nxt   = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CH_W'(1);
            state_nxt = ST_MLO;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_cnt_r  <= CC_W'(CC_RESET);
      win_samp_r  <= WIN_W'(WIN_RESET);
      win_cnt_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        max_r[i] <= MM_NEG;
        min_r[i] <= MM_POS;
        sum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      chan_cnt_r  <= chan_cnt_nxt;
      win_samp_r  <= win_samp_nxt;
      win_cnt_r   <= win_cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    x_r        <= x_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/wprm_checker.sv
`timescale 1ns / 1ps

module wprm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [wprm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast
);

  import wprm_pkg::*;

  // The block never takes a sample while a result is on offer
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("sample port ready while a result is pending");

  // A stalled result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A sample transaction starts work, so the port closes on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample port stayed open after a transaction");

  // Only the last result of a window returns the block to idle
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> (in_tready == $past(out_tlast)))
    else $error("idle state does not follow the window's last result");

  // Reset leaves the block idle with nothing on offer
  a_rst: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind windowed_peak_rms_meter wprm_checker u_wprm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/sv/windowed_peak_rms_meter_tb.sv
`timescale 1ns / 1ps

module windowed_peak_rms_meter_tb;

  localparam int MAX_CHANNELS  = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int FULL_SCALE    = 1 << (SAMPLE_BITS - 1);
  localparam int ROOT_SHIFT    = 2 * (SAMPLE_BITS - 1);
  localparam int RANDOM_ITEMS  = 310;
  localparam int CALM_ITEMS    = 60;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 200;
  localparam int TAIL_CYCLES   = 1500;
  localparam int MAX_REPORTS   = 100;
  localparam logic [23:0] WIN_LONGEST = 24'hFF_FFFF;

  // One level triplet as the block should emit it.
  typedef struct {
    logic [2:0]  channel;
    logic [10:0] peak_high;
    logic [10:0] peak_low;
    logic [9:0]  rms_level;
    logic        last;
  } level_t;

  // Level predictor with its own copy of the registers and the window state.
  class level_scoreboard;
    logic [3:0]        chan_cfg;
    logic [23:0]       win_cfg;
    int                hi_peak[MAX_CHANNELS];
    int                lo_peak[MAX_CHANNELS];
    longint unsigned   energy[MAX_CHANNELS];
    int unsigned       taken;
    int unsigned       next_chan;
    level_t            due_levels[$];
    int                fail_count;

    function new();
      chan_cfg   = 4'(wprm_pkg::CC_RESET);
      win_cfg    = 24'(wprm_pkg::WIN_RESET);
      next_chan  = 0;
      fail_count = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hi_peak[i] = -FULL_SCALE;
        lo_peak[i] = FULL_SCALE;
        energy[i]  = 0;
      end
      taken = 0;
    endfunction

    function void write_reg(logic [wprm_pkg::CFG_IDX_W-1:0] idx,
                            logic [wprm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        wprm_pkg::CFG_CHANNEL_COUNT:  chan_cfg = val[3:0];
        wprm_pkg::CFG_WINDOW_SAMPLES: win_cfg  = val[23:0];
        default: ;
      endcase
    endfunction

    // A count of zero behaves as one; anything above the maximum is clamped.
    function int unsigned active_channels();
      if (chan_cfg == 0) return 1;
      if (chan_cfg > MAX_CHANNELS) return MAX_CHANNELS;
      return chan_cfg;
    endfunction

    // Integer division in SystemVerilog truncates toward zero, as required.
    function logic [10:0] peak_code(int v);
      int scaled;
      scaled = (v * wprm_pkg::LEVEL_SCALE) / FULL_SCALE;
      return scaled[10:0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x    = x - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    // Mean square split into quotient and remainder so that the scaled
    // value keeps its fraction; saturates at full scale.
    function logic [9:0] rms_code(longint unsigned sum, longint unsigned div);
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned scaled;
      longint unsigned root;
      quo = sum / div;
      rem = sum % div;
      if ((quo >> (ROOT_SHIFT + 1)) != 0) return 10'(wprm_pkg::LEVEL_SCALE);
      scaled = quo * 64'(wprm_pkg::RMS_SCALE) + (rem * 64'(wprm_pkg::RMS_SCALE)) / div;
      root = int_sqrt(scaled >> ROOT_SHIFT);
      if (root > wprm_pkg::LEVEL_SCALE) root = wprm_pkg::LEVEL_SCALE;
      return root[9:0];
    endfunction

    // Called for every accepted sample transaction.
    function void note_sample(logic [15:0] code);
      int              s;
      longint          sl;
      int unsigned     eff;
      int unsigned     ch;
      longint unsigned div;
      level_t          lv;
      s   = $signed(code);
      sl  = s;
      eff = active_channels();
      if (next_chan >= eff) next_chan = 0;
      ch = next_chan;
      if (s < lo_peak[ch]) lo_peak[ch] = s;
      if (s > hi_peak[ch]) hi_peak[ch] = s;
      energy[ch] = energy[ch] + longint'(sl * sl);
      next_chan  = (ch + 1 >= eff) ? 0 : ch + 1;
      taken      = (taken + 1) & 32'h00FF_FFFF;
      if (taken < win_cfg) return;

      // Window closed: one triplet per active channel, channel 0 first.
      div = taken / eff;
      if (div == 0) div = 1;
      for (int unsigned j = 0; j < eff; j++) begin
        lv.channel   = j[2:0];
        lv.peak_high = peak_code(hi_peak[j]);
        lv.peak_low  = peak_code(lo_peak[j]);
        lv.rms_level = rms_code(energy[j], div);
        lv.last      = (j + 1 == eff);
        due_levels.push_back(lv);
      end
      clear_window();
    endfunction

    task report_mismatch(string msg);
      if (fail_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
    endtask

    // Called for every accepted result transaction.
    task check_level(logic [2:0] chan, logic [31:0] data, logic tl);
      level_t lv;
      if (due_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level result, channel %0d data %h", chan, data));
        return;
      end
      lv = due_levels.pop_front();
      if (chan !== lv.channel)
        report_mismatch($sformatf("channel %0d, want %0d", chan, lv.channel));
      if (data[10:0] !== lv.peak_high)
        report_mismatch($sformatf("ch %0d peak_high %0d, want %0d", lv.channel,
                                  $signed(data[10:0]), $signed(lv.peak_high)));
      if (data[21:11] !== lv.peak_low)
        report_mismatch($sformatf("ch %0d peak_low %0d, want %0d", lv.channel,
                                  $signed(data[21:11]), $signed(lv.peak_low)));
      if (data[31:22] !== lv.rms_level)
        report_mismatch($sformatf("ch %0d rms_level %0d, want %0d", lv.channel,
                                  data[31:22], lv.rms_level));
      if (tl !== lv.last)
        report_mismatch($sformatf("ch %0d tlast %b, want %b", lv.channel, tl, lv.last));
    endtask

    function int pending();
      return due_levels.size();
    endfunction
  endclass

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic [wprm_pkg::CFG_IDX_W-1:0]     cfg_index = wprm_pkg::CFG_CHANNEL_COUNT;
  logic [wprm_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [15:0]                        in_tdata  = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [wprm_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic [wprm_pkg::OUT_USER_W-1:0]    out_tuser;
  logic                               out_tlast;

  level_scoreboard meter_sb;
  bit              idle_on       = 1'b1;
  bit              long_hold_req = 1'b0;
  int              sent_count    = 0;

  windowed_peak_rms_meter #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // in_tdata: sample [15:0]
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // out_tdata: peak_high [10:0], peak_low [21:11], rms_level [31:22]
    .out_tdata (out_tdata),
    // out_tuser: channel [2:0]
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Give up after a generous bound on the slowest legal run.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one sample and wait for the transaction; may then go idle for a burst.
  task automatic send_sample(input logic [15:0] code);
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (in_tready !== 1'b1);
    meter_sb.note_sample(code);
    sent_count++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every outstanding level, then let the block go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic configure(input logic [3:0] chans, input logic [23:0] win);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= wprm_pkg::CFG_CHANNEL_COUNT;
    cfg_wdata <= 24'(chans);
    @(posedge clk);
    cfg_index <= wprm_pkg::CFG_WINDOW_SAMPLES;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
    meter_sb.write_reg(wprm_pkg::CFG_CHANNEL_COUNT, 24'(chans));
    meter_sb.write_reg(wprm_pkg::CFG_WINDOW_SAMPLES, win);
  endtask

  // Mostly full-range codes, with corners and quiet passages mixed in.
  function automatic logic [15:0] pick_sample();
    int quiet;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1, 2: begin
        quiet = int'($urandom_range(0, 511)) - 256;
        return quiet[15:0];
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : level_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        meter_sb.check_level(out_tuser, out_tdata, out_tlast);
      if (long_hold_req) begin
        hold_left     = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed windows, random windows, drain.
  initial begin
    int          phase_no;
    int          burst;
    logic [3:0]  chans;
    logic [23:0] win;
    meter_sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-sample windows on a single channel: the peak extremes and sign corners.
    configure(4'd0, 24'd1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // Three channels over four samples: channel 0 gets two full-scale
    // negatives against a divisor of one, so its level saturates.
    configure(4'd3, 24'd4);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);

    // Count above the maximum, short window: most channels go unfed.
    configure(4'd15, 24'd3);
    send_sample(16'h1234);
    send_sample(16'hEDCC);
    send_sample(16'h4000);

    // Zero window: every sample closes one.
    configure(4'd2, 24'd0);
    send_sample(16'hC000);
    send_sample(16'h3FFF);

    // Longest window left open, then the channel count drops mid-window and a
    // shorter window closes it.
    configure(4'd4, WIN_LONGEST);
    for (int i = 0; i < 6; i++) send_sample(pick_sample());
    configure(4'd1, 24'd8);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // Random windows; the first one runs against a long result hold-off and
    // the closing stretch runs without any idling.
    sent_count = 0;
    phase_no   = 0;
    while (sent_count < RANDOM_ITEMS) begin
      chans = 4'($urandom_range(0, 15));
      burst = $urandom_range(15, 45);
      case ($urandom_range(0, 9))
        0: begin
          win   = 24'd0;
          burst = $urandom_range(3, 12);
        end
        1:       win = WIN_LONGEST;
        default: win = 24'($urandom_range(1, 48));
      endcase
      if (phase_no == 0) begin
        chans = 4'd4;
        win   = 24'd8;
        burst = 40;
      end
      configure(chans, win);
      if (sent_count >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (phase_no == 0) long_hold_req = 1'b1;
      for (int i = 0; i < burst; i++) send_sample(pick_sample());
      phase_no++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (meter_sb.fail_count == 0 && meter_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
